// ----- sv/mapw_pkg.sv -----
// shared types and constants of the pooling engine
package mapw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_READ,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [2:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_KERNEL_SIZE   = 3'd3;
    localparam logic [2:0] REG_STRIDE_STEP   = 3'd4;
    localparam logic [2:0] REG_PAD_ENABLE    = 3'd5;
    localparam logic [2:0] REG_POOL_TYPE     = 3'd6;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic POOL_MAX = 1'b0;
    localparam logic POOL_AVG = 1'b1;

    localparam int MODE_BITS    = 1;
    localparam int CHANNEL_BITS = 4;
    localparam int COORD_BITS   = 6;
    localparam int FIELD_BITS   = 16;

endpackage

// ----- sv/mapw_if.sv -----
// valid/ready channel interfaces for requests and results
interface mapw_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [3:0]                channel;
    logic [5:0]                row;
    logic [5:0]                col;
    logic signed [15:0]        sample;
    modport source (output valid, mode, channel, row, col, sample, input ready);
    modport sink   (input valid, mode, channel, row, col, sample, output ready);
endinterface

interface mapw_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        pooled_value;
    logic                      out_of_range;
    modport source (output valid, pooled_value, out_of_range, input ready);
    modport sink   (input valid, pooled_value, out_of_range, output ready);
endinterface

// ----- sv/max_avg_pooling_window_top.sv -----
// pooling engine top level: sample store, window sequencer and serial divider
//
//  channel  dir  handshake           payload
//  in       in   valid/ready         mode channel row col sample
//  out      out  valid/ready         pooled_value out_of_range
//  apb      in   psel/penable/pready map, kernel, stride, pad, pool registers
//
// a write request is written in the idle state; a query walks the window through the read
// and accumulate states, plus 16 divider steps for the average; a rejected query skips both
// the window loop reads one stored sample per read and accumulate pair from the store's read port
// reset is asynchronous active low and clears the configuration, state and output valid, not the store
// a result waits in the output register while the next request is taken
module max_avg_pooling_window_top #(
    parameter int MAX_DIM      = 64,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_KERNEL   = 15,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mapw_in_if.sink     in_ch,
    mapw_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mapw_pkg::*;

    localparam int DB = $clog2(MAX_DIM);
    localparam int CB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AB = CB + 2 * DB;
    localparam int DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int SB = SAMPLE_BITS + 8;
    localparam int NB = 8;
    localparam int QB = 16;
    localparam int PB = 16;

    logic [6:0] map_width_reg, map_height_reg, stride_step_reg;
    logic [4:0] channel_count_reg;
    logic [3:0] kernel_size_reg;
    logic       pad_enable_reg, pool_type_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg     <= 7'd64;
            map_height_reg    <= 7'd64;
            channel_count_reg <= 5'd16;
            kernel_size_reg   <= 4'd2;
            stride_step_reg   <= 7'd2;
            pad_enable_reg    <= 1'b0;
            pool_type_reg     <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_MAP_WIDTH:     map_width_reg     <= pwdata[6:0];
                REG_MAP_HEIGHT:    map_height_reg    <= pwdata[6:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[4:0];
                REG_KERNEL_SIZE:   kernel_size_reg   <= pwdata[3:0];
                REG_STRIDE_STEP:   stride_step_reg   <= pwdata[6:0];
                REG_PAD_ENABLE:    pad_enable_reg    <= pwdata[0];
                REG_POOL_TYPE:     pool_type_reg     <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_MAP_WIDTH:     prdata = {25'd0, map_width_reg};
            REG_MAP_HEIGHT:    prdata = {25'd0, map_height_reg};
            REG_CHANNEL_COUNT: prdata = {27'd0, channel_count_reg};
            REG_KERNEL_SIZE:   prdata = {28'd0, kernel_size_reg};
            REG_STRIDE_STEP:   prdata = {25'd0, stride_step_reg};
            REG_PAD_ENABLE:    prdata = {31'd0, pad_enable_reg};
            REG_POOL_TYPE:     prdata = {31'd0, pool_type_reg};
            default:           prdata = '0;
        endcase
    end

    // effective configuration
    logic [8:0] w_eff, h_eff, nc_eff, k_eff, s_eff;
    always_comb
    begin
        w_eff  = (32'(map_width_reg) > MAX_DIM) ? 9'(MAX_DIM) : 9'(map_width_reg);
        h_eff  = (32'(map_height_reg) > MAX_DIM) ? 9'(MAX_DIM) : 9'(map_height_reg);
        nc_eff = (32'(channel_count_reg) > MAX_CHANNELS) ? 9'(MAX_CHANNELS)
                                                        : 9'(channel_count_reg);
        k_eff  = (kernel_size_reg == 4'd0) ? 9'd1 : 9'(kernel_size_reg);
        if (32'(k_eff) > MAX_KERNEL)
            k_eff = 9'(MAX_KERNEL);
        s_eff  = (stride_step_reg == 7'd0) ? 9'd1 : 9'(stride_step_reg);
    end

    // sample store
    logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AB-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AB-1:0]                 wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [3:0]  ch_reg;
    logic [5:0]  row_reg, col_reg;
    logic [9:0]  x0_reg, y0_reg, x1_reg, y1_reg, x_reg, y_reg;
    logic signed [SB-1:0] sum_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic [NB-1:0] cnt_reg;
    logic [QB+PB-1:0] rem_reg;
    logic [QB-1:0] quo_reg;
    logic [5:0]  step_reg;
    logic        neg_reg;
    logic signed [15:0] res_reg;
    logic        oor_reg, ovalid_reg;

    logic [QB-1:0] ucnt;
    assign ucnt = QB'(cnt_reg);

    // bad query: zero size, kernel above map size, channel out of range, or position*stride past the last start
    logic bad;
    logic [12:0] xs_full, ys_full;
    logic [8:0]  lim_w, lim_h;
    logic [9:0] xs, ys, off;
    always_comb
    begin
        lim_w   = pad_enable_reg ? w_eff - 9'd1 : w_eff - k_eff;
        lim_h   = pad_enable_reg ? h_eff - 9'd1 : h_eff - k_eff;
        xs_full = 13'(col_reg) * 13'(s_eff[6:0]);
        ys_full = 13'(row_reg) * 13'(s_eff[6:0]);
        bad = (w_eff == 9'd0) || (h_eff == 9'd0) || (nc_eff == 9'd0) ||
              (k_eff > w_eff) || (k_eff > h_eff) || (9'(ch_reg) >= nc_eff);
        if (!bad && ((xs_full > 13'(lim_w)) || (ys_full > 13'(lim_h))))
            bad = 1'b1;
        off = pad_enable_reg ? 10'((k_eff - 9'd1) >> 1) : 10'd0;
        xs  = xs_full[9:0];
        ys  = ys_full[9:0];
    end

    logic [QB+PB:0] trial;
    assign trial = {rem_reg, 1'b0} - {1'b0, ucnt, {PB{1'b0}}};

    assign rd_addr = AB'({ch_reg, y_reg[DB-1:0], x_reg[DB-1:0]});
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign wr_en   = in_ch.valid && in_ch.ready && (in_ch.mode == MODE_WRITE) &&
                     (32'(in_ch.channel) < MAX_CHANNELS) && (32'(in_ch.row) < MAX_DIM) &&
                     (32'(in_ch.col) < MAX_DIM);
    assign wr_addr = AB'({CB'(in_ch.channel), DB'(in_ch.row), DB'(in_ch.col)});
    assign wr_data = SAMPLE_BITS'(in_ch.sample);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_ch.valid && in_ch.ready && in_ch.mode == MODE_QUERY)
                          state_next = ST_CHECK;
            ST_CHECK: state_next = bad ? ST_OUT : ST_SETUP;
            ST_SETUP: state_next = ST_READ;
            ST_READ:  state_next = ST_ACC;
            ST_ACC:   if (x_reg + 10'd1 >= x1_reg && y_reg + 10'd1 >= y1_reg)
                          state_next = (pool_type_reg == POOL_AVG) ? ST_DIV : ST_OUT;
                      else
                          state_next = ST_READ;
            ST_DIV:   if (step_reg == 6'(QB - 1))
                          state_next = ST_OUT;
            ST_OUT:   if (!ovalid_reg || out_ch.ready)
                          state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ch.ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_OUT && (!ovalid_reg || out_ch.ready))
                ovalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                ch_reg  <= in_ch.channel;
                row_reg <= in_ch.row;
                col_reg <= in_ch.col;
                oor_reg <= 1'b0;
            end
            ST_CHECK:
            begin
                oor_reg <= bad;
                res_reg <= '0;
                x0_reg  <= (xs < off) ? 10'd0 : xs - off;
                y0_reg  <= (ys < off) ? 10'd0 : ys - off;
                x1_reg  <= (xs + 10'(k_eff) - off > 10'(w_eff)) ? 10'(w_eff)
                                                                : xs + 10'(k_eff) - off;
                y1_reg  <= (ys + 10'(k_eff) - off > 10'(h_eff)) ? 10'(h_eff)
                                                                : ys + 10'(k_eff) - off;
            end
            ST_SETUP:
            begin
                x_reg   <= x0_reg;
                y_reg   <= y0_reg;
                sum_reg <= '0;
                cnt_reg <= '0;
                max_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
            ST_READ: ;
            ST_ACC:
            begin
                sum_reg <= sum_reg + SB'(rd_data_reg);
                cnt_reg <= cnt_reg + NB'(1);
                if (rd_data_reg > max_reg)
                    max_reg <= rd_data_reg;
                if (x_reg + 10'd1 >= x1_reg)
                begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + 10'd1;
                end
                else
                    x_reg <= x_reg + 10'd1;
                res_reg <= 16'(rd_data_reg > max_reg ? rd_data_reg : max_reg);
                neg_reg <= (sum_reg + SB'(rd_data_reg)) < 0;
                rem_reg <= (QB+PB)'(((sum_reg + SB'(rd_data_reg)) < 0)
                           ? -(sum_reg + SB'(rd_data_reg)) : (sum_reg + SB'(rd_data_reg)));
                step_reg <= '0;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                step_reg <= step_reg + 6'd1;
                if (!trial[QB+PB])
                begin
                    rem_reg <= trial[QB+PB-1:0];
                    quo_reg <= {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[QB+PB-2:0], 1'b0};
                    quo_reg <= {quo_reg[QB-2:0], 1'b0};
                end
                if (step_reg == 6'(QB - 1))
                    res_reg <= neg_reg ? -16'({quo_reg[QB-2:0], !trial[QB+PB]})
                                       : 16'({quo_reg[QB-2:0], !trial[QB+PB]});
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    logic signed [15:0] pv_reg;
    logic               po_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!ovalid_reg || out_ch.ready))
        begin
            pv_reg <= oor_reg ? 16'sd0 : res_reg;
            po_reg <= oor_reg;
        end
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.pooled_value = pv_reg;
    assign out_ch.out_of_range = po_reg;

endmodule

// ----- tb/max_avg_pooling_window_top_test.sv -----
// testbench for the pooling engine: self-checking scoreboard, random requests, register phases
`timescale 1ns / 100ps

module max_avg_pooling_window_top_test;
    import mapw_pkg::*;

    typedef struct {
        logic signed [15:0] value;
        logic               oor;
    } pooled_t;

    class PoolScoreboard;
        logic signed [15:0] samples [65536];
        bit                 written [65536];
        logic [6:0]         map_w;
        logic [6:0]         map_h;
        logic [4:0]         chans;
        logic [3:0]         kern;
        logic [6:0]         stride;
        logic               pad;
        logic               pool;
        pooled_t            pending_q[$];
        int                 mismatches;

        function new();
            map_w = 64;
            map_h = 64;
            chans = 16;
            kern = 2;
            stride = 2;
            pad = 0;
            pool = POOL_MAX;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_MAP_WIDTH:     map_w = v[6:0];
                REG_MAP_HEIGHT:    map_h = v[6:0];
                REG_CHANNEL_COUNT: chans = v[4:0];
                REG_KERNEL_SIZE:   kern = v[3:0];
                REG_STRIDE_STEP:   stride = v[6:0];
                REG_PAD_ENABLE:    pad = v[0];
                REG_POOL_TYPE:     pool = v[0];
                default: ;
            endcase
        endfunction

        function void eff(output int w, output int h, output int nc, output int k,
                          output int s);
            w = (map_w > 64) ? 64 : map_w;
            h = (map_h > 64) ? 64 : map_h;
            nc = (chans > 16) ? 16 : chans;
            k = (kern == 0) ? 1 : kern;
            s = (stride == 0) ? 1 : stride;
        endfunction

        function int out_dim(int dim, int k, int s);
            if (pad)
                return (dim - 1) / s + 1;
            return (dim - k) / s + 1;
        endfunction

        function bit window_of(int ch, int r, int c, output int x0, output int y0,
                               output int x1, output int y1);
            int w, h, nc, k, s, off;
            eff(w, h, nc, k, s);
            x0 = 0;
            y0 = 0;
            x1 = 0;
            y1 = 0;
            if (w == 0 || h == 0 || nc == 0 || k > w || k > h || ch >= nc)
                return 0;
            if (c >= out_dim(w, k, s) || r >= out_dim(h, k, s))
                return 0;
            off = pad ? (k - 1) / 2 : 0;
            x0 = c * s - off;
            y0 = r * s - off;
            x1 = x0 + k;
            y1 = y0 + k;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > w) x1 = w;
            if (y1 > h) y1 = h;
            return 1;
        endfunction

        function void note_request(logic mode, logic [3:0] ch, logic [5:0] r, logic [5:0] c,
                                   logic signed [15:0] smp);
            int x0, y0, x1, y1, cnt, idx;
            longint sum, maxv;
            pooled_t e;
            if (mode == MODE_WRITE) begin
                idx = (int'(ch) * 64 + int'(r)) * 64 + int'(c);
                samples[idx] = smp;
                written[idx] = 1;
                return;
            end
            e.value = '0;
            e.oor = 1'b1;
            if (window_of(ch, r, c, x0, y0, x1, y1)) begin
                sum = 0;
                cnt = 0;
                maxv = -32768;
                for (int y = y0; y < y1; y++)
                    for (int x = x0; x < x1; x++) begin
                        idx = (int'(ch) * 64 + y) * 64 + x;
                        if (samples[idx] > maxv)
                            maxv = samples[idx];
                        sum += samples[idx];
                        cnt++;
                    end
                e.oor = 1'b0;
                if (cnt == 0)
                    e.value = '0;
                else if (pool == POOL_AVG)
                    e.value = 16'(sum / cnt);
                else
                    e.value = 16'(maxv);
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(logic signed [15:0] v, logic oor);
            pooled_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d oor %0b", v, oor);
                return;
            end
            e = pending_q.pop_front();
            if (v !== e.value || oor !== e.oor) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected value %0d oor %0b, got value %0d oor %0b",
                             e.value, e.oor, v, oor);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mapw_in_if  in_if ();
    mapw_out_if out_if ();

    max_avg_pooling_window_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    PoolScoreboard sb = new();
    int tx_idle;
    int rx_idle;
    int hold_request;
    int sent;

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #120_000_000;
        $display("max_avg_pooling_window_top regression: fail");
        $finish;
    end

    // result side: random stalls plus a long hold-off on request
    initial begin
        int hold;
        hold = 0;
        out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.pooled_value, out_if.out_of_range);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else
                out_if.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send(logic mode, logic [3:0] ch, logic [5:0] r, logic [5:0] c,
                        logic [15:0] smp);
        while ($urandom_range(99) < tx_idle) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode <= mode;
        in_if.channel <= ch;
        in_if.row <= r;
        in_if.col <= c;
        in_if.sample <= smp;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_request(mode, ch, r, c, smp);
        sent++;
    endtask

    // writes every unwritten sample of the window before the query goes out
    task automatic query(logic [3:0] ch, logic [5:0] r, logic [5:0] c);
        int x0, y0, x1, y1;
        if (sb.window_of(ch, r, c, x0, y0, x1, y1))
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++)
                    if (!sb.written[(int'(ch) * 64 + y) * 64 + x])
                        send(MODE_WRITE, ch, 6'(y), 6'(x), 16'($urandom));
        send(MODE_QUERY, ch, r, c, 16'($urandom));
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic configure(int mw, int mh, int nc, int k, int s, int pd, int pl);
        drain();
        reg_write(REG_MAP_WIDTH, 32'(mw));
        reg_write(REG_MAP_HEIGHT, 32'(mh));
        reg_write(REG_CHANNEL_COUNT, 32'(nc));
        reg_write(REG_KERNEL_SIZE, 32'(k));
        reg_write(REG_STRIDE_STEP, 32'(s));
        reg_write(REG_PAD_ENABLE, 32'(pd));
        reg_write(REG_POOL_TYPE, 32'(pl));
    endtask

    // sends about n requests, window fills included
    task automatic random_items(int n);
        int w, h, nc, k, s, pick, ow, oh, stop;
        sb.eff(w, h, nc, k, s);
        stop = sent + n;
        while (sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 60 && w > 0 && h > 0 && nc > 0 && k <= w && k <= h) begin
                ow = sb.out_dim(w, k, s);
                oh = sb.out_dim(h, k, s);
                query(4'($urandom_range(nc - 1)), 6'($urandom_range(oh - 1)),
                      6'($urandom_range(ow - 1)));
            end else if (pick < 85)
                send(MODE_WRITE, 4'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
            else
                query(4'($urandom), 6'($urandom), 6'($urandom));
        end
    endtask

    initial begin
        int mw, mh, k;
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_if.valid <= 1'b0;
        in_if.mode <= MODE_WRITE;
        in_if.channel <= '0;
        in_if.row <= '0;
        in_if.col <= '0;
        in_if.sample <= '0;
        tx_idle = 20;
        rx_idle = 59;
        hold_request = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme samples under the reset settings
        send(MODE_WRITE, 4'd0, 6'd0, 6'd0, 16'h7fff);
        send(MODE_WRITE, 4'd0, 6'd0, 6'd1, 16'h8000);
        send(MODE_WRITE, 4'd0, 6'd1, 6'd0, 16'h0000);
        send(MODE_WRITE, 4'd0, 6'd1, 6'd1, 16'hffff);
        query(4'd0, 6'd0, 6'd0);
        send(MODE_WRITE, 4'd15, 6'd62, 6'd62, 16'h8000);
        send(MODE_WRITE, 4'd15, 6'd62, 6'd63, 16'h8000);
        send(MODE_WRITE, 4'd15, 6'd63, 6'd62, 16'h8000);
        send(MODE_WRITE, 4'd15, 6'd63, 6'd63, 16'h8000);
        query(4'd15, 6'd31, 6'd31);
        query(4'd15, 6'd32, 6'd0);
        query(4'd0, 6'd63, 6'd63);
        configure(2, 2, 1, 2, 1, 0, 1);
        query(4'd0, 6'd0, 6'd0);
        query(4'd1, 6'd0, 6'd0);

        // saturating register values, single padded window
        configure(127, 127, 31, 15, 127, 1, 1);
        query(4'd15, 6'd0, 6'd0);
        random_items(20);
        // zero map width, zero kernel and stride
        configure(0, 5, 4, 0, 0, 0, 0);
        random_items(15);
        configure(5, 5, 0, 2, 1, 0, 1);
        random_items(15);
        // kernel wider than the map
        configure(3, 8, 4, 4, 1, 1, 0);
        random_items(15);
        configure(7, 6, 3, 0, 0, 1, 0);
        random_items(30);

        for (int p = 0; p < 15; p++) begin
            if (p == 5) begin
                tx_idle = 59;
                rx_idle = 20;
            end
            if (p == 10) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            mw = $urandom_range(1, 12);
            mh = $urandom_range(1, 12);
            if (p == 7 || p == 12) begin
                mw = 64;
                mh = 64;
            end
            k = $urandom_range(1, (mw < mh ? mw : mh) > 15 ? 15 : (mw < mh ? mw : mh));
            if ($urandom_range(9) == 0)
                k = $urandom_range(1, 15);
            if (p == 12)
                k = 15;
            configure(mw, mh, $urandom_range(1, 16), k, $urandom_range(1, 4),
                      $urandom_range(1), $urandom_range(1));
            if (p == 11)
                hold_request = 3000;
            random_items((p == 7 || p == 12) ? 15 : 80);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("max_avg_pooling_window_top regression: pass");
        else
            $display("max_avg_pooling_window_top regression: fail");
        $finish;
    end

endmodule
